[rtl/stp_pkg.sv]
`timescale 1ns / 1ps
package stp_pkg;

	localparam int AXES          = 6;
	localparam int LINEAR_AXES   = 3;
	localparam int AXIS_IDX_W    = 3;
	localparam int WORD_W        = 32;
	localparam int CFG_W         = 31;
	localparam int MUL_W         = 32;
	localparam int PROD_W        = 2 * MUL_W;
	localparam int STP_POS_WIDTH = 32;

	// request kinds carried on the input tuser
	typedef logic [1:0] req_t;
	localparam req_t REQ_TICK = 2'd0;
	localparam req_t REQ_MOVE = 2'd1;
	localparam req_t REQ_STOP = 2'd2;

	// configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_MAX_SPEED  = 2'd0;
	localparam cfg_idx_t CFG_ACCEL_STEP = 2'd1;
	localparam cfg_idx_t CFG_TOLERANCE  = 2'd2;

	localparam logic [CFG_W-1:0] MAX_SPEED_RST  = 31'd655360;
	localparam logic [CFG_W-1:0] ACCEL_STEP_RST = 31'd16384;
	localparam logic [CFG_W-1:0] TOLERANCE_RST  = 31'd66;

	// v/20 rounded: (|v| + 10) >> 2, then times ceil(2^32 / 5), keep high word
	localparam logic [WORD_W-1:0] ROUND_BIAS = 32'd10;
	localparam logic [MUL_W-1:0]  RECIP_5    = 32'd858993460;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef struct packed {
		logic start;
		req_t req;
	} stp_cmd_t;

	typedef struct packed {
		logic idle;
		logic done;
	} stp_stat_t;

endpackage

[rtl/stp_mul.sv]
`timescale 1ns / 1ps
// shared 32x32 unsigned multiplier, product registered
module stp_mul
	import stp_pkg::*;
(
	input  logic              clk,
	input  logic [MUL_W-1:0]  op_a,
	input  logic [MUL_W-1:0]  op_b,
	output logic [PROD_W-1:0] prod
);

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
	end

	assign prod = prod_q;

endmodule

[rtl/stp_core.sv]
`timescale 1ns / 1ps
// axis state and per-axis sequencer around the shared multiplier
module stp_core
	import stp_pkg::*;
#(
	parameter int POS_WIDTH = STP_POS_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  stp_cmd_t         cmd,
	input  word_t            target [AXES],
	input  logic [CFG_W-1:0] max_speed,
	input  logic [CFG_W-1:0] accel_step,
	input  logic [CFG_W-1:0] tolerance,
	input  logic             done_ack,
	output stp_stat_t        stat,
	output word_t            pos_out [AXES],
	output logic             moving
);

	localparam int SW = ((POS_WIDTH > WORD_W) ? POS_WIDTH : WORD_W) + 2;
	localparam int DW = POS_WIDTH + 1;
	localparam int CW = (DW > CFG_W) ? DW : CFG_W;
	localparam int VW = WORD_W + 2;

	typedef logic signed [POS_WIDTH-1:0] pos_t;

	localparam logic signed [SW-1:0] P_MAX = {{(SW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
	localparam logic signed [SW-1:0] P_MIN = {{(SW-POS_WIDTH+1){1'b1}}, {(POS_WIDTH-1){1'b0}}};
	localparam logic signed [SW-1:0] W_MAX = {{(SW-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
	localparam logic signed [SW-1:0] W_MIN = {{(SW-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_DIFF = 10'b00_0000_0010,
		S_SQ   = 10'b00_0000_0100,
		S_LO   = 10'b00_0000_1000,
		S_HI   = 10'b00_0001_0000,
		S_CMP  = 10'b00_0010_0000,
		S_VEL  = 10'b00_0100_0000,
		S_DIV  = 10'b00_1000_0000,
		S_POS  = 10'b01_0000_0000,
		S_DONE = 10'b10_0000_0000
	} state_t;

	function automatic pos_t sat_pos(input logic signed [SW-1:0] x);
		if (x > P_MAX) return P_MAX[POS_WIDTH-1:0];
		if (x < P_MIN) return P_MIN[POS_WIDTH-1:0];
		return x[POS_WIDTH-1:0];
	endfunction

	function automatic word_t sat_word(input logic signed [SW-1:0] x);
		if (x > W_MAX) return W_MAX[WORD_W-1:0];
		if (x < W_MIN) return W_MIN[WORD_W-1:0];
		return x[WORD_W-1:0];
	endfunction

	state_t                 state_q;
	logic [AXIS_IDX_W-1:0]  k_q;
	pos_t                   pos_q [AXES];
	word_t                  vel_q [AXES];
	pos_t                   tgt_q [AXES];
	logic                   active_q;
	logic                   all_q;

	// per-axis working registers
	logic                   diff_pos_q;
	logic [DW-1:0]          ad_q;
	logic [DW-1:0]          m_q;
	logic [WORD_W-1:0]      av_q;
	logic [PROD_W-1:0]      xsq_q;
	logic [PROD_W-1:0]      plo_q;
	logic                   stop_q;
	logic                   far_q;
	word_t                  vnew_q;

	logic [MUL_W-1:0]       mul_a;
	logic [MUL_W-1:0]       mul_b;
	logic [PROD_W-1:0]      prod;

	pos_t                   pos_k;
	pos_t                   tgt_k;
	word_t                  vel_k;
	logic signed [DW-1:0]   diff_c;
	logic [DW-1:0]          ad_c;
	logic [WORD_W-1:0]      av_c;
	logic [CFG_W-1:0]       a_eff;
	logic [PROD_W-1:0]      m_ext;
	logic [PROD_W+MUL_W-1:0] y_c;
	logic                   stop_c;
	logic                   far_c;
	logic [CFG_W-1:0]       vmax_c;
	logic signed [VW-1:0]   vs, as_s, tv, up, dn, vn;
	logic [WORD_W-1:0]      avn;
	logic [WORD_W-1:0]      rnd;
	logic signed [SW-1:0]   d_ext;
	logic signed [SW-1:0]   step;
	logic signed [SW-1:0]   sum;

	stp_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	assign pos_k = pos_q[k_q];
	assign tgt_k = tgt_q[k_q];
	assign vel_k = vel_q[k_q];

	// distance to go and speed magnitude
	assign diff_c = $signed({tgt_k[POS_WIDTH-1], tgt_k}) - $signed({pos_k[POS_WIDTH-1], pos_k});
	assign ad_c   = diff_c[DW-1] ? DW'(-diff_c) : DW'(diff_c);
	assign av_c   = vel_k[WORD_W-1] ? WORD_W'(-vel_k) : WORD_W'(vel_k);

	assign a_eff  = (accel_step == '0) ? CFG_W'(1) : accel_step;
	assign m_ext  = PROD_W'(m_q);

	// stop test: v^2 / 2a > |diff|  <=>  v^2 >= 2 * (|diff| + 1) * a
	assign y_c    = {prod, {MUL_W{1'b0}}} + {{MUL_W{1'b0}}, plo_q};
	assign stop_c = {{(MUL_W+1){1'b0}}, xsq_q} >= {y_c, 1'b0};
	assign far_c  = CW'(ad_q) > CW'(tolerance);

	// velocity update
	assign vmax_c = (k_q < AXIS_IDX_W'(LINEAR_AXES)) ? max_speed : (max_speed >> 1);
	assign vs     = $signed({{2{vel_k[WORD_W-1]}}, vel_k});
	assign as_s   = $signed({3'b000, accel_step});
	assign tv     = diff_pos_q ? $signed({3'b000, vmax_c}) : -$signed({3'b000, vmax_c});
	assign up     = vs + as_s;
	assign dn     = vs - as_s;

	always_comb begin
		vn = vs;
		if (stop_q) begin
			if (vs > 0)
				vn = (dn < 0) ? '0 : dn;
			else if (vs < 0)
				vn = (up > 0) ? '0 : up;
		end else begin
			if (vs < tv)
				vn = (up > tv) ? tv : up;
			else if (vs > tv)
				vn = (dn < tv) ? tv : dn;
		end
	end

	// rounded v/20 and saturating advance
	assign avn   = vnew_q[WORD_W-1] ? WORD_W'(-vnew_q) : WORD_W'(vnew_q);
	assign rnd   = avn + ROUND_BIAS;
	assign d_ext = SW'(prod[PROD_W-1:MUL_W]);
	assign step  = vnew_q[WORD_W-1] ? -d_ext : d_ext;
	assign sum   = $signed({{(SW-POS_WIDTH){pos_k[POS_WIDTH-1]}}, pos_k}) + step;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQ: begin
				mul_a = av_q;
				mul_b = av_q;
			end
			S_LO: begin
				mul_a = m_ext[MUL_W-1:0];
				mul_b = MUL_W'(a_eff);
			end
			S_HI: begin
				mul_a = m_ext[PROD_W-1:MUL_W];
				mul_b = MUL_W'(a_eff);
			end
			S_DIV: begin
				mul_a = {2'b00, rnd[WORD_W-1:2]};
				mul_b = RECIP_5;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DIFF) begin
			diff_pos_q <= ~diff_c[DW-1] & (|diff_c);
			ad_q       <= ad_c;
			m_q        <= ad_c + 1'b1;
			av_q       <= av_c;
		end
		if (state_q == S_LO)
			xsq_q <= prod;
		if (state_q == S_HI)
			plo_q <= prod;
		if (state_q == S_CMP) begin
			stop_q <= stop_c;
			far_q  <= far_c;
		end
		if (state_q == S_VEL)
			vnew_q <= vn[WORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			k_q      <= '0;
			active_q <= 1'b0;
			all_q    <= 1'b0;
			for (int i = 0; i < AXES; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				tgt_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						unique case (cmd.req)
							REQ_MOVE: begin
								for (int i = 0; i < AXES; i++)
									tgt_q[i] <= sat_pos($signed({{(SW-WORD_W){target[i][WORD_W-1]}},
										target[i]}));
								active_q <= 1'b1;
								state_q  <= S_DONE;
							end
							REQ_STOP: begin
								for (int i = 0; i < AXES; i++)
									vel_q[i] <= '0;
								active_q <= 1'b0;
								state_q  <= S_DONE;
							end
							REQ_TICK: begin
								k_q     <= '0;
								all_q   <= 1'b1;
								state_q <= active_q ? S_DIFF : S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_DIFF: state_q <= S_SQ;
				S_SQ:   state_q <= S_LO;
				S_LO:   state_q <= S_HI;
				S_HI:   state_q <= S_CMP;
				S_CMP:  state_q <= S_VEL;
				S_VEL:  state_q <= S_DIV;
				S_DIV:  state_q <= S_POS;
				S_POS: begin
					if (far_q) begin
						pos_q[k_q] <= sat_pos(sum);
						vel_q[k_q] <= vnew_q;
					end else begin
						pos_q[k_q] <= tgt_k;
						vel_q[k_q] <= '0;
					end
					all_q <= all_q & ~far_q;
					if (k_q == AXIS_IDX_W'(AXES - 1)) begin
						active_q <= active_q & ~(all_q & ~far_q);
						state_q  <= S_DONE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_DIFF;
					end
				end
				S_DONE: if (done_ack) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < AXES; i++)
			pos_out[i] = sat_word($signed({{(SW-POS_WIDTH){pos_q[i][POS_WIDTH-1]}}, pos_q[i]}));
	end

	assign moving    = active_q;
	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = (state_q == S_DONE);

`ifndef ASSERT_OFF
	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		k_q < AXIS_IDX_W'(AXES))
		else $error("axis counter out of range");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && done_ack |=> (state_q == S_IDLE))
		else $error("done not released after ack");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && cmd.start && (cmd.req == REQ_STOP) |=>
		!active_q && (vel_q[0] == '0) && (vel_q[1] == '0) && (vel_q[2] == '0) &&
		(vel_q[3] == '0) && (vel_q[4] == '0) && (vel_q[5] == '0))
		else $error("stop left motion state");

	a_moving_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(active_q) |-> ($past(state_q) == S_POS) ||
		(($past(state_q) == S_IDLE) && $past(cmd.start)))
		else $error("moving cleared outside a tick or stop");
`endif

endmodule

[rtl/six_axis_trapezoid_profile.sv]
`timescale 1ns / 1ps
// Six-axis trapezoidal velocity profiler, Q16.16 positions and speeds.
// Input stream: tuser carries the request kind (tick, move, stop), tdata the
// six targets, used by a move only. Output stream: one result per request,
// tdata holds the six positions after the request, tuser the moving flag.
// Config channel: cfg_index selects max_speed, accel_step or tolerance;
// write only while no request is in flight. cfg_ready is always high.
// Sequencing: a tick while moving walks the six axes through one shared 32x32
// multiplier, one axis after another, in the steps distance, v^2, two partial
// products of the braking distance, compare, velocity step, v/20 and position
// write; move, stop and idle ticks go from idle straight to the done state.
// The next request is taken only when the sequencer is back to idle, also
// while a result still waits in the output register.
// Back pressure: a stalled output holds the finished result; the sequencer
// waits in its done state and takes no further request until it drains.
// Reset: positions, velocities and targets go to zero, moving clears and the
// registers return to 10.0 top speed, 0.25 step and 66 LSB tolerance.
module six_axis_trapezoid_profile
	import stp_pkg::*;
#(
	parameter int POS_WIDTH = STP_POS_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// target_x, target_y, target_z, target_u, target_v, target_w (32 each)
	input  logic [AXES*WORD_W-1:0]   s_axis_tdata,
	// req_type
	input  logic [1:0]               s_axis_tuser,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// pos_x, pos_y, pos_z, pos_u, pos_v, pos_w (32 each)
	output logic [AXES*WORD_W-1:0]   m_axis_tdata,
	// moving
	output logic                     m_axis_tuser,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [CFG_W-1:0]         cfg_data
);

	logic [CFG_W-1:0]        max_speed_q;
	logic [CFG_W-1:0]        accel_step_q;
	logic [CFG_W-1:0]        tolerance_q;

	logic                    out_valid_q;
	logic [AXES*WORD_W-1:0]  out_data_q;
	logic                    out_moving_q;

	stp_cmd_t                cmd;
	stp_stat_t               stat;
	word_t                   target [AXES];
	word_t                   pos_out [AXES];
	logic                    moving;
	logic                    done_ack;

	// request enters only when the sequencer is idle
	assign s_axis_tready = stat.idle;
	assign cmd.start     = s_axis_tvalid & stat.idle;
	assign cmd.req       = s_axis_tuser;

	always_comb begin
		for (int i = 0; i < AXES; i++)
			target[i] = s_axis_tdata[i*WORD_W +: WORD_W];
	end

	stp_core #(
		.POS_WIDTH (POS_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.target     (target),
		.max_speed  (max_speed_q),
		.accel_step (accel_step_q),
		.tolerance  (tolerance_q),
		.done_ack   (done_ack),
		.stat       (stat),
		.pos_out    (pos_out),
		.moving     (moving)
	);

	// config writes; unknown indexes drop silently
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q  <= MAX_SPEED_RST;
			accel_step_q <= ACCEL_STEP_RST;
			tolerance_q  <= TOLERANCE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAX_SPEED:  max_speed_q  <= cfg_data;
				CFG_ACCEL_STEP: accel_step_q <= cfg_data;
				CFG_TOLERANCE:  tolerance_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// output register: loads when the slot is empty or draining this cycle
	assign done_ack = stat.done & (~out_valid_q | m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (done_ack)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done_ack) begin
			for (int i = 0; i < AXES; i++)
				out_data_q[i*WORD_W +: WORD_W] <= pos_out[i];
			out_moving_q <= moving;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_moving_q;

endmodule
